>>> hw/rtl/tick_deadline_wakeup_queue_assert.svh
// Assertion macros shared by the wake-up queue RTL.
`ifndef TICK_DEADLINE_WAKEUP_QUEUE_ASSERT_SVH
`define TICK_DEADLINE_WAKEUP_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TDWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define TDWQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);
`else
`define TDWQ_ASSERT(lbl, prop, msg)
`define TDWQ_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> hw/rtl/tdwq_pkg.sv
// Types and constants of the tick deadline wake-up queue.
`timescale 1ns / 1ps
`default_nettype none
package tdwq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned TID_W       = 16;
  localparam int unsigned RATE_W      = 16;
  localparam int unsigned MOD_CNT_W   = $clog2(TICK_W + 1);
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic              FUNC_ARM    = 1'b1;
  localparam logic [1:0]        KIND_ARM    = 2'd0;
  localparam logic [1:0]        KIND_TICK   = 2'd1;
  localparam logic [1:0]        KIND_WAKE   = 2'd2;
  localparam logic [1:0]        STATUS_OK   = 2'd0;
  localparam logic [1:0]        STATUS_DUP  = 2'd1;
  localparam logic [1:0]        STATUS_FULL = 2'd2;
  localparam logic              REG_TPS     = 1'b0;
  localparam logic [RATE_W-1:0] TPS_RESET   = 16'd1000;

  typedef struct packed {
    logic              func;
    logic [TICK_W-1:0] deadline;
    logic [TID_W-1:0]  thread_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [TID_W-1:0]  woken_thread;
    logic [TICK_W-1:0] tick_count;
    logic              second_mark;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [TID_W-1:0]  thread;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RATE_W-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/tdwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tdwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                   wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/tdwq_mod.sv
// Bit-serial remainder of the tick count by the tick rate, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tdwq_mod (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tdwq_pkg::mod_req_t req_i,
  output tdwq_pkg::mod_rsp_t      rsp_o
);

  logic [tdwq_pkg::RATE_W-1:0]    r_q, r_d;
  logic [tdwq_pkg::TICK_W-1:0]    dvd_q, dvd_d;
  logic [tdwq_pkg::RATE_W-1:0]    dvs_q, dvs_d;
  logic [tdwq_pkg::MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tdwq_pkg::RATE_W:0]      trial;
  logic [tdwq_pkg::RATE_W:0]      dvs_ext;

  assign trial   = {r_q, dvd_q[tdwq_pkg::TICK_W-1]};
  assign dvs_ext = {1'b0, dvs_q};

  always_comb begin
    r_d    = r_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      r_d    = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = tdwq_pkg::MOD_CNT_W'(tdwq_pkg::TICK_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step: shift in the next dividend bit, subtract if it fits
      if (trial >= dvs_ext) begin
        r_d = tdwq_pkg::RATE_W'(trial - dvs_ext);
      end else begin
        r_d = trial[tdwq_pkg::RATE_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - tdwq_pkg::MOD_CNT_W'(1);
      if (cnt_q == tdwq_pkg::MOD_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      r_q    <= r_d;
      dvd_q  <= dvd_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // hold busy through the done cycle so the result lands before the next tick
  assign rsp_o.busy = busy_q | done_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;

endmodule
`default_nettype wire

>>> hw/rtl/tick_deadline_wakeup_queue.sv
// Top level of the tick deadline wake-up queue.
//
// Command channel: an item transfers at a rising edge with start high and
// busy low. func = 0 advances the tick counter; func = 1 arms a deadline with
// a thread id. Results leave on result_o, one per cycle at most, each valid
// for exactly one cycle under result_strobe_o; the receiver cannot stall, and
// last marks the final result of an item.
// Entries live in a single RAM (one read, one write port, registered read
// data), so every pass walks the queue one entry per cycle. Each item runs as:
//   arm:  a scan of the queue, then the result when rejected; when inserted,
//         a shift of the entries from the slot up, then the write and result.
//   tick: the tick report comes first, then one wake result per expired
//         entry, in queue order.
// busy stays high until the final result is on the port, so items are taken
// one at a time.
// A write of ticks_per_second over the APB port recomputes count mod rate in
// a bit-serial unit; busy stays high until the new remainder is stored.
// Reset empties the queue, clears the tick counter and sets the rate to 1000;
// the RAM needs no clearing pass, as only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "tick_deadline_wakeup_queue_assert.svh"
module tick_deadline_wakeup_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire tdwq_pkg::cmd_t                cmd_i,
  output logic                               busy,
  output tdwq_pkg::result_t                  result_o,
  output logic                               result_strobe_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tdwq_pkg::APB_AW-1:0]   paddr,
  input  wire logic [tdwq_pkg::APB_DW-1:0]   pwdata,
  output logic      [tdwq_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM_SCAN,
    ST_ARM_SHIFT,
    ST_ARM_PUT,
    ST_TICK_SCAN
  } state_e;

  localparam logic [tdwq_pkg::CNT_W-1:0] DEPTH_CNT =
    tdwq_pkg::CNT_W'(tdwq_pkg::QUEUE_DEPTH);
  localparam logic [tdwq_pkg::CNT_W-1:0] CNT_ONE = tdwq_pkg::CNT_W'(1);

  state_e                        state_q, state_d;
  logic [tdwq_pkg::TICK_W-1:0]   now_q, now_d;
  logic [tdwq_pkg::RATE_W-1:0]   rem_q, rem_d;
  logic [tdwq_pkg::RATE_W-1:0]   tps_q, tps_d;
  logic [tdwq_pkg::CNT_W-1:0]    count_q, count_d;
  tdwq_pkg::cmd_t                cmd_q, cmd_d;
  logic [tdwq_pkg::CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [tdwq_pkg::CNT_W-1:0]    pos_q, pos_d;
  logic [tdwq_pkg::CNT_W-1:0]    keep_q, keep_d;
  logic                          dup_q, dup_d;
  tdwq_pkg::result_t             pend_q, pend_d;
  tdwq_pkg::result_t             out_q, out_d;
  logic                          out_vld_q, out_vld_d;

  logic                          accept;
  logic                          cfg_wr;
  logic                          rd_issue;
  logic                          ram_we;
  logic [tdwq_pkg::IDX_W-1:0]    ram_waddr;
  logic [tdwq_pkg::IDX_W-1:0]    ram_raddr;
  tdwq_pkg::entry_t              wr_entry;
  logic [tdwq_pkg::ENTRY_W-1:0]  ram_rdata;
  tdwq_pkg::entry_t              rd_entry;
  logic [tdwq_pkg::CNT_W-1:0]    rd_inc;
  logic [tdwq_pkg::CNT_W-1:0]    rd_dec;
  logic [tdwq_pkg::TICK_W-1:0]   now_inc;
  logic [tdwq_pkg::RATE_W-1:0]   rem_inc;
  logic [tdwq_pkg::RATE_W-1:0]   tick_rem;
  logic [tdwq_pkg::TICK_W-1:0]   diff;
  tdwq_pkg::mod_req_t            mod_req;
  tdwq_pkg::mod_rsp_t            mod_rsp;

  tdwq_ram #(
    .WIDTH (tdwq_pkg::ENTRY_W),
    .DEPTH (tdwq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tdwq_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign rd_entry = tdwq_pkg::entry_t'(ram_rdata);
  assign busy     = (state_q != ST_IDLE) || mod_rsp.busy;
  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[tdwq_pkg::APB_AW-1] == tdwq_pkg::REG_TPS) ?
                    tdwq_pkg::APB_DW'(tps_q) : '0;

  assign rd_inc   = rd_idx_q + CNT_ONE;
  assign rd_dec   = rd_idx_q - CNT_ONE;
  assign now_inc  = now_q + tdwq_pkg::TICK_W'(1);
  assign rem_inc  = rem_q + tdwq_pkg::RATE_W'(1);
  // residue of the new count; the counter wrapping to zero restarts it
  assign tick_rem = ((now_inc == '0) || (rem_inc == tps_q)) ? '0 : rem_inc;
  assign diff     = rd_entry.deadline - now_q;

  assign mod_req.start    = cfg_wr && (paddr[tdwq_pkg::APB_AW-1] == tdwq_pkg::REG_TPS);
  assign mod_req.dividend = now_q;
  assign mod_req.divisor  = pwdata[tdwq_pkg::RATE_W-1:0];

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    rem_d     = rem_q;
    tps_d     = tps_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = 1'b0;
    pos_d     = pos_q;
    keep_d    = keep_q;
    dup_d     = dup_q;
    pend_d    = pend_q;
    out_d     = out_q;
    out_vld_d = 1'b0;
    rd_issue  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_raddr = rd_idx_q[tdwq_pkg::IDX_W-1:0];
    wr_entry  = rd_entry;

    if (mod_req.start) begin
      tps_d = pwdata[tdwq_pkg::RATE_W-1:0];
    end
    if (mod_rsp.done) begin
      rem_d = mod_rsp.rem;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          rd_idx_d = '0;
          pos_d    = '0;
          keep_d   = '0;
          dup_d    = 1'b0;
          if (cmd_i.func == tdwq_pkg::FUNC_ARM) begin
            state_d = ST_ARM_SCAN;
          end else begin
            now_d              = now_inc;
            rem_d              = tick_rem;
            pend_d             = '0;
            pend_d.kind        = tdwq_pkg::KIND_TICK;
            pend_d.tick_count  = now_inc;
            pend_d.second_mark = (tps_q != '0) && (tick_rem == '0);
            state_d            = ST_TICK_SCAN;
          end
        end
      end
      ST_ARM_SCAN: begin
        if (rd_idx_q != count_q) begin
          rd_issue = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_inc;
        end
        if (rd_vld_q) begin
          if (rd_entry.deadline == cmd_q.deadline) begin
            dup_d = 1'b1;
          end
          // queue is sorted, so the entries below the new deadline give its slot
          if (rd_entry.deadline < cmd_q.deadline) begin
            pos_d = pos_q + CNT_ONE;
          end
        end else if (rd_idx_q == count_q) begin
          if (dup_q || (count_q == DEPTH_CNT)) begin
            out_d        = '0;
            out_d.kind   = tdwq_pkg::KIND_ARM;
            out_d.status = dup_q ? tdwq_pkg::STATUS_DUP : tdwq_pkg::STATUS_FULL;
            out_d.last   = 1'b1;
            out_vld_d    = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_ARM_SHIFT;
          end
        end
      end
      ST_ARM_SHIFT: begin
        // walk down from the tail, moving each entry one slot up
        if (rd_idx_q != pos_q) begin
          rd_issue  = 1'b1;
          ram_raddr = rd_dec[tdwq_pkg::IDX_W-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = rd_dec;
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_inc[tdwq_pkg::IDX_W-1:0];
        end else if (rd_idx_q == pos_q) begin
          state_d = ST_ARM_PUT;
        end
      end
      ST_ARM_PUT: begin
        ram_we            = 1'b1;
        ram_waddr         = pos_q[tdwq_pkg::IDX_W-1:0];
        wr_entry.deadline = cmd_q.deadline;
        wr_entry.thread   = cmd_q.thread_id;
        count_d           = count_q + CNT_ONE;
        out_d             = '0;
        out_d.kind        = tdwq_pkg::KIND_ARM;
        out_d.status      = tdwq_pkg::STATUS_OK;
        out_d.last        = 1'b1;
        out_vld_d         = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_TICK_SCAN: begin
        if (rd_idx_q != count_q) begin
          rd_issue = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_inc;
        end
        if (rd_vld_q) begin
          if (diff[tdwq_pkg::TICK_W-1]) begin
            // release the held result; hold the wake until we know if it is last
            out_d               = pend_q;
            out_vld_d           = 1'b1;
            pend_d              = '0;
            pend_d.kind         = tdwq_pkg::KIND_WAKE;
            pend_d.woken_thread = rd_entry.thread;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = keep_q[tdwq_pkg::IDX_W-1:0];
            keep_d    = keep_q + CNT_ONE;
          end
        end else if (rd_idx_q == count_q) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          count_d    = keep_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      now_q     <= '0;
      rem_q     <= '0;
      tps_q     <= tdwq_pkg::TPS_RESET;
      count_q   <= '0;
      cmd_q     <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      pos_q     <= '0;
      keep_q    <= '0;
      dup_q     <= 1'b0;
      pend_q    <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      rem_q     <= rem_d;
      tps_q     <= tps_d;
      count_q   <= count_d;
      cmd_q     <= cmd_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      pos_q     <= pos_d;
      keep_q    <= keep_d;
      dup_q     <= dup_d;
      pend_q    <= pend_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign result_o        = out_q;
  assign result_strobe_o = out_vld_q;

  `TDWQ_ASSERT(a_count_bound, count_q <= DEPTH_CNT, "entry count beyond queue depth")
  `TDWQ_ASSERT(a_last_gap, out_vld_q && out_q.last |=> !out_vld_q, "result right after last")
  `TDWQ_ASSERT_NEVER(a_rw_collide, ram_we && rd_issue && (ram_waddr == ram_raddr), "RAM read and write hit the same entry")
  `TDWQ_ASSERT_NEVER(a_stray_read, rd_vld_q && (state_q == ST_IDLE || state_q == ST_ARM_PUT), "read data returned outside a pass")
  `TDWQ_ASSERT(a_insert_count, out_vld_q && out_q.kind == tdwq_pkg::KIND_ARM && out_q.status == tdwq_pkg::STATUS_OK |-> count_q == $past(count_q) + CNT_ONE, "insert did not grow the queue")

endmodule
`default_nettype wire
